### hdl/cpg_pkg.sv
// Shared constants, codes and inter-stage records of the circle pixel generator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cpg_pkg;

    localparam int LINE_BYTES    = 80;
    localparam int RASTER_HEIGHT = 512;

    localparam int COORD_W = 10;
    localparam int RAD_W   = 9;
    localparam int PIX_W   = 12;
    localparam int DEC_W   = 13;
    localparam int ASP_W   = 11;
    localparam int OFF_W   = 16;
    localparam int MASK_W  = 8;
    localparam int IDX_W   = 3;

    localparam logic [PIX_W:0]   LINE_PX     = (PIX_W + 1)'(LINE_BYTES * 8);
    localparam logic [PIX_W-1:0] RASTER_ROWS = PIX_W'(RASTER_HEIGHT);
    localparam logic [8:0]       LINE_BYTES_W = 9'(LINE_BYTES);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(7);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y = 1'b1;

    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [ASP_W-1:0]   ay;
        logic [ASP_W-1:0]   by;
        logic               done;
    } t_step_rec;

    typedef struct packed {
        logic                    valid;
        logic signed [PIX_W-1:0] px;
        logic signed [PIX_W-1:0] py;
        logic                    last;
        logic                    done;
    } t_pix;

endpackage

`default_nettype wire

### hdl/cpg_in_if.sv
// Request channel of the circle pixel generator: start flag, centre and radius.
// Depends on cpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface cpg_in_if;
    import cpg_pkg::*;

    logic               valid;
    logic               ready;
    logic               start_req;
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [RAD_W-1:0]   radius;

    modport source (output valid, start_req, center_x, center_y, radius, input ready);
    modport sink   (input valid, start_req, center_x, center_y, radius, output ready);
endinterface

`default_nettype wire

### hdl/cpg_out_if.sv
// Pixel result channel of the circle pixel generator.
// Depends on cpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface cpg_out_if;
    import cpg_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
    logic                    in_raster;
    logic [OFF_W-1:0]        byte_offset;
    logic [MASK_W-1:0]       bit_mask;
    logic                    last_of_step;
    logic                    circle_done;

    modport source (output valid, pixel_x, pixel_y, in_raster, byte_offset, bit_mask,
                    last_of_step, circle_done, input ready);
    modport sink   (input valid, pixel_x, pixel_y, in_raster, byte_offset, bit_mask,
                    last_of_step, circle_done, output ready);
endinterface

`default_nettype wire

### hdl/cpg_stepper.sv
// Midpoint stepper: circle state, one step per transaction, step record register.
// Depends on cpg_pkg and cpg_in_if.
`timescale 1ns / 1ps
`default_nettype none

module cpg_stepper (
    input  logic               i_clk,
    input  logic               i_rst_n,
    cpg_in_if.sink             i_req,
    input  logic               i_release,
    output cpg_pkg::t_step_rec o_rec
);
    import cpg_pkg::*;

    localparam int               RECIP_SHIFT = 16;
    localparam int               PROD_W      = 27;
    localparam logic [PROD_W-1:0] RECIP_10   = PROD_W'(6554);

    logic [COORD_W-1:0] r_step_x;
    logic [COORD_W-1:0] r_step_y;
    logic [DEC_W-1:0]   r_dec;
    logic [COORD_W-1:0] r_cx;
    logic [COORD_W-1:0] r_cy;
    logic               r_active;
    t_step_rec          r_rec;

    logic               accept;
    logic               run;
    logic [COORD_W-1:0] x_cur;
    logic [COORD_W-1:0] y_cur;
    logic [DEC_W-1:0]   d_cur;
    logic [COORD_W-1:0] cx_cur;
    logic [COORD_W-1:0] cy_cur;
    logic [DEC_W-1:0]   n_dec;
    logic signed [PIX_W-1:0] x_nxt;
    logic signed [PIX_W-1:0] y_nxt;
    logic               done;
    logic [13:0]        x11;
    logic [13:0]        y11;
    logic [PROD_W-1:0]  x_prod;
    logic [PROD_W-1:0]  y_prod;
    t_step_rec          n_rec;

    assign i_req.ready = !r_rec.valid || i_release;
    assign accept      = i_req.valid && i_req.ready;
    assign run         = i_req.start_req || r_active;

    always_comb begin
        if (i_req.start_req) begin
            x_cur  = '0;
            y_cur  = COORD_W'(i_req.radius);
            d_cur  = DEC_W'(3) - (DEC_W'(i_req.radius) << 1);
            cx_cur = i_req.center_x;
            cy_cur = i_req.center_y;
        end else begin
            x_cur  = r_step_x;
            y_cur  = r_step_y;
            d_cur  = r_dec;
            cx_cur = r_cx;
            cy_cur = r_cy;
        end

        x_nxt = $signed(PIX_W'(x_cur)) + PIX_W'(1);
        if (d_cur[DEC_W-1]) begin
            n_dec = d_cur + (DEC_W'(x_cur) << 2) + DEC_W'(6);
            y_nxt = $signed(PIX_W'(y_cur));
        end else begin
            n_dec = d_cur + ((DEC_W'(x_cur) - DEC_W'(y_cur)) << 2) + DEC_W'(10);
            y_nxt = $signed(PIX_W'(y_cur)) - PIX_W'(1);
        end
        done = x_nxt > y_nxt;

        // aspect 11/10, truncating: multiply by 11 then by a reciprocal of ten
        x11    = (14'(x_cur) << 3) + (14'(x_cur) << 1) + 14'(x_cur);
        y11    = (14'(y_cur) << 3) + (14'(y_cur) << 1) + 14'(y_cur);
        x_prod = PROD_W'(x11) * RECIP_10;
        y_prod = PROD_W'(y11) * RECIP_10;

        n_rec.valid = 1'b1;
        n_rec.cx    = cx_cur;
        n_rec.cy    = cy_cur;
        n_rec.x0    = x_cur;
        n_rec.y0    = y_cur;
        n_rec.ay    = y_prod[RECIP_SHIFT +: ASP_W];
        n_rec.by    = x_prod[RECIP_SHIFT +: ASP_W];
        n_rec.done  = done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_x    <= '0;
            r_step_y    <= '0;
            r_dec       <= '0;
            r_cx        <= '0;
            r_cy        <= '0;
            r_active    <= 1'b0;
            r_rec.valid <= 1'b0;
        end else if (accept && run) begin
            r_step_x <= x_nxt[COORD_W-1:0];
            r_step_y <= y_nxt[COORD_W-1:0];
            r_dec    <= n_dec;
            r_cx     <= cx_cur;
            r_cy     <= cy_cur;
            r_active <= !done;
            r_rec    <= n_rec;
        end else if (i_release) begin
            r_rec.valid <= 1'b0;
        end
    end

    assign o_rec = r_rec;

    a_step_loads_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && run) |=> r_rec.valid)
        else $error("step ran without a record");

endmodule

`default_nettype wire

### hdl/cpg_emitter.sv
// Octant emitter: walks the eight mirrored pixels of a step into a pixel register.
// Depends on cpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpg_emitter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cpg_pkg::t_step_rec i_rec,
    input  logic               i_ready,
    output logic               o_release,
    output cpg_pkg::t_pix      o_pix
);
    import cpg_pkg::*;

    logic [IDX_W-1:0] r_idx;
    t_pix             r_pix;

    logic               pix_free;
    logic               advance;
    logic               use_y;
    logic               neg_col;
    logic               neg_row;
    logic [COORD_W-1:0] lateral;
    logic [ASP_W-1:0]   vert;
    t_pix               n_pix;

    assign pix_free  = !r_pix.valid || i_ready;
    assign advance   = i_rec.valid && pix_free;
    assign o_release = advance && (r_idx == IDX_LAST);

    always_comb begin
        use_y   = r_idx[2];
        neg_col = r_idx[1];
        neg_row = r_idx[1] ^ r_idx[0];
        lateral = use_y ? i_rec.y0 : i_rec.x0;
        vert    = use_y ? i_rec.by : i_rec.ay;

        n_pix.valid = advance;
        n_pix.px    = neg_col ? $signed(PIX_W'(i_rec.cx) - PIX_W'(lateral))
                              : $signed(PIX_W'(i_rec.cx) + PIX_W'(lateral));
        n_pix.py    = neg_row ? $signed(PIX_W'(i_rec.cy) - PIX_W'(vert))
                              : $signed(PIX_W'(i_rec.cy) + PIX_W'(vert));
        n_pix.last  = (r_idx == IDX_LAST);
        n_pix.done  = (r_idx == IDX_LAST) && i_rec.done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_pix.valid <= 1'b0;
        end else begin
            if (advance) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (pix_free) begin
                r_pix <= n_pix;
            end
        end
    end

    assign o_pix = r_pix;

    a_idx_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rec.valid |-> (r_idx == '0))
        else $error("pixel index not rewound between steps");

endmodule

`default_nettype wire

### hdl/cpg_addr.sv
// Address stage: raster check, scaled bitplane byte offset and bit mask into the output register.
// Depends on cpg_pkg and cpg_out_if.
`timescale 1ns / 1ps
`default_nettype none

module cpg_addr (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_scale_x,
    input  logic          i_scale_y,
    input  cpg_pkg::t_pix i_pix,
    output logic          o_ready,
    cpg_out_if.source     o_res
);
    import cpg_pkg::*;

    logic                    r_valid;
    logic signed [PIX_W-1:0] r_px;
    logic signed [PIX_W-1:0] r_py;
    logic                    r_in_raster;
    logic [OFF_W-1:0]        r_offset;
    logic [MASK_W-1:0]       r_mask;
    logic                    r_last;
    logic                    r_done;

    logic              on_raster;
    logic [10:0]       sx;
    logic [9:0]        sy;
    logic [8:0]        bpl;
    logic [18:0]       row_base;
    logic [OFF_W-1:0]  n_offset;
    logic [MASK_W-1:0] n_mask;

    assign o_ready = !r_valid || o_res.ready;

    always_comb begin
        on_raster = !i_pix.px[PIX_W-1] && ({1'b0, $unsigned(i_pix.px)} < LINE_PX)
                 && !i_pix.py[PIX_W-1] && ($unsigned(i_pix.py) < RASTER_ROWS);
        sx        = $unsigned(i_pix.px[10:0]) >> i_scale_x;
        sy        = $unsigned(i_pix.py[9:0]) >> i_scale_y;
        bpl       = LINE_BYTES_W >> i_scale_x;
        row_base  = 19'(sy) * 19'(bpl);
        n_offset  = on_raster ? OFF_W'(row_base + 19'(sx[10:3])) : '0;
        n_mask    = on_raster ? (MASK_W'(8'h80) >> sx[2:0]) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid     <= i_pix.valid;
            r_px        <= i_pix.px;
            r_py        <= i_pix.py;
            r_in_raster <= on_raster;
            r_offset    <= n_offset;
            r_mask      <= n_mask;
            r_last      <= i_pix.last;
            r_done      <= i_pix.done;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.pixel_x      = r_px;
    assign o_res.pixel_y      = r_py;
    assign o_res.in_raster    = r_in_raster;
    assign o_res.byte_offset  = r_offset;
    assign o_res.bit_mask     = r_mask;
    assign o_res.last_of_step = r_last;
    assign o_res.circle_done  = r_done;

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_in_raster) |-> (r_offset == '0 && r_mask == '0))
        else $error("pixel outside raster carries an address");

    a_inside_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_in_raster) |-> $onehot(r_mask))
        else $error("pixel inside raster lacks a one-hot mask");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_done) |-> r_last)
        else $error("circle end flagged before the last pixel of a step");

endmodule

`default_nettype wire

### hdl/circle_pixel_generator.sv
// Circle pixel generator top level: scale registers, stepper, octant emitter, address stage.
// Depends on cpg_pkg, cpg_in_if, cpg_out_if, cpg_stepper, cpg_emitter and cpg_addr.
//
// Usage:
//   i_req carries one transaction per circle step. With start_req high it loads the
//   centre and radius and runs the first step; with it low it runs the next step of
//   the current circle, or is dropped when no circle is active.
//   o_pix returns eight transactions per step in octant order, each with its column,
//   row, raster flag, bitplane byte offset and bit mask; last_of_step marks the
//   eighth and circle_done marks the eighth of the final step.
//   i_cfg_we writes scale_x (index 0) or scale_y (index 1); write only while idle.
// Timing:
//   A taken request passes through the step record, the emitter's pixel register and
//   the output register of the address stage before its first pixel reaches o_pix.
//   Pixels follow one per cycle when o_pix is not stalled, set by the octant counter
//   feeding o_pix; the next request is taken in the cycle the eighth pixel of the
//   current step leaves the emitter, so steps follow without a gap.
// Reset clears the circle state, the scale registers and all valid flags. When the
// receiver stalls, each stage holds its pixel and the request side waits.
`timescale 1ns / 1ps
`default_nettype none

module circle_pixel_generator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [cpg_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [cpg_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    cpg_in_if.sink                           i_req,
    cpg_out_if.source                        o_pix
);
    import cpg_pkg::*;

    logic      r_scale_x;
    logic      r_scale_y;
    t_step_rec step_rec;
    logic      rec_release;
    t_pix      pix;
    logic      pix_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_x <= 1'b0;
            r_scale_y <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SCALE_X: begin
                    r_scale_x <= i_cfg_wdata[0];
                end
                CFG_SCALE_Y: begin
                    r_scale_y <= i_cfg_wdata[0];
                end
            endcase
        end
    end

    cpg_stepper u_stepper (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .i_release (rec_release),
        .o_rec     (step_rec)
    );

    cpg_emitter u_emitter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rec     (step_rec),
        .i_ready   (pix_ready),
        .o_release (rec_release),
        .o_pix     (pix)
    );

    cpg_addr u_addr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_scale_x (r_scale_x),
        .i_scale_y (r_scale_y),
        .i_pix     (pix),
        .o_ready   (pix_ready),
        .o_res     (o_pix)
    );

endmodule

`default_nettype wire
